// ===== hdl/cbe_pkg.sv =====
package cbe_pkg;

    localparam int unsigned OP_LEN_W   = 28;
    localparam int unsigned SUM_W      = 31;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned LIMIT_W    = 10;

    localparam logic [SUM_W-1:0]   SUM_MAX         = 31'h7FFF_FFFF;
    localparam logic [LIMIT_W-1:0] OP_LIMIT_RESET  = 10'd255;

    localparam logic [3:0] OP_M = 4'd0;
    localparam logic [3:0] OP_I = 4'd1;
    localparam logic [3:0] OP_D = 4'd2;
    localparam logic [3:0] OP_N = 4'd3;
    localparam logic [3:0] OP_S = 4'd4;
    localparam logic [3:0] OP_H = 4'd5;
    localparam logic [3:0] OP_P = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X = 4'd8;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [15:0] BIN_OFF_L5 = 16'(((1 << 15) - 1) / 7);
    localparam logic [15:0] BIN_OFF_L4 = 16'(((1 << 12) - 1) / 7);
    localparam logic [15:0] BIN_OFF_L3 = 16'(((1 << 9) - 1) / 7);
    localparam logic [15:0] BIN_OFF_L2 = 16'(((1 << 6) - 1) / 7);
    localparam logic [15:0] BIN_OFF_L1 = 16'(((1 << 3) - 1) / 7);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PARSE  = 2'd1,
        PH_IGNORE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  ch;
        logic        end_of_string;
        logic [27:0] seq_len;
        logic [28:0] map_pos;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [27:0] op_length;
        logic [3:0]  op_code;
        logic [10:0] op_count;
        logic [30:0] ref_span;
        logic [15:0] bin;
        logic        record_done;
    } t_out_item;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
    } t_push;

    function automatic logic [3:0] op_code_of(input logic [7:0] ch);
        logic [3:0] code;
        unique case (ch)
            8'h4D:   code = OP_M;
            8'h49:   code = OP_I;
            8'h44:   code = OP_D;
            8'h4E:   code = OP_N;
            8'h53:   code = OP_S;
            8'h48:   code = OP_H;
            8'h50:   code = OP_P;
            8'h3D:   code = OP_EQ;
            default: code = OP_X;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] reg2bin(input logic [28:0] beg_pos,
                                            input logic [30:0] span);
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] s;
        logic [15:0] res;
        b = {3'b000, beg_pos};
        s = b + {1'b0, span};
        e = s - 32'd1;
        if (s == 32'd0) begin
            res = 16'd0;
        end else if ((b >> 14) == (e >> 14)) begin
            res = BIN_OFF_L5 + 16'(b >> 14);
        end else if ((b >> 17) == (e >> 17)) begin
            res = BIN_OFF_L4 + 16'(b >> 17);
        end else if ((b >> 20) == (e >> 20)) begin
            res = BIN_OFF_L3 + 16'(b >> 20);
        end else if ((b >> 23) == (e >> 23)) begin
            res = BIN_OFF_L2 + 16'(b >> 23);
        end else if ((b >> 26) == (e >> 26)) begin
            res = BIN_OFF_L1 + 16'(b >> 26);
        end else begin
            res = 16'd0;
        end
        return res;
    endfunction

endpackage

// ===== hdl/cigar_to_bam_op_encoder_core.sv =====
// CIGAR text to BAM op word encoder.
// The input channel carries one CIGAR character per beat, with the read length and
// the mapping position alongside; a beat with end_of_string set closes the record.
// The output channel carries op word beats (kind 0) and one summary beat per record
// (kind 1) holding the op count, the mapped length and the index bin.
// The op limit register is written through i_cfg_we and i_cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
// It resets to 255. An input beat is taken into the input register, processed once
// the result queue has room and written into a four-entry result queue, so the
// first result beat passes through the input register and the queue before it is offered.
// One input beat is accepted every cycle while the queue has room; a beat that
// triggers truncation yields two result beats. The queue accepts work only while it
// has room for two results. When the receiver stalls, the queue fills and the input
// ready falls; nothing is lost. Reset empties the queue and the input register,
// restores the op limit and returns the parser to the start of a record.
module cigar_to_bam_op_encoder_core import cbe_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data
);

    logic [LIMIT_W-1:0] r_op_limit;
    logic               room;
    t_push              push;
    t_out_item          res_a;
    t_out_item          res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_limit <= OP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_op_limit <= i_cfg_wdata;
        end
    end

    cbe_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_op_limit (r_op_limit),
        .i_room     (room),
        .o_push     (push),
        .o_res_a    (res_a),
        .o_res_b    (res_b)
    );

    cbe_res_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res_a     (res_a),
        .i_res_b     (res_b),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/cbe_engine.sv =====
module cbe_engine import cbe_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 28
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    input  logic [LIMIT_W-1:0]  i_op_limit,
    input  logic                i_room,
    output t_push               o_push,
    output t_out_item           o_res_a,
    output t_out_item           o_res_b
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};
    localparam logic [SUM_W-1:0]       LEN_MAX_W = SUM_W'(LEN_MAX);

    logic                   r_in_valid;
    t_in_item               r_in;
    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [SUM_W-1:0]       r_ref, n_ref;
    logic [SUM_W-1:0]       r_read, n_read;
    logic [COUNT_W-1:0]     r_ops, n_ops;

    logic                   advance;
    logic                   is_star;
    logic                   is_digit;
    logic                   active;
    logic                   trunc_hit;
    logic [3:0]             code;
    logic [3:0]             digit;
    logic [LENGTH_BITS+3:0] acc_next;
    logic [SUM_W:0]         ref_sum;
    logic [SUM_W:0]         read_sum;
    logic [SUM_W-1:0]       read_upd;
    logic [SUM_W-1:0]       clip_raw;
    logic [COUNT_W-1:0]     ops_inc;

    assign advance    = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || advance;

    assign is_star  = (r_in.ch == CH_STAR);
    assign is_digit = (r_in.ch >= CH_ZERO) && (r_in.ch <= CH_NINE);
    assign active   = (r_phase == PH_PARSE) || ((r_phase == PH_START) && !is_star);
    assign code     = op_code_of(r_in.ch);
    assign digit    = 4'(r_in.ch - CH_ZERO);
    assign ops_inc  = r_ops + COUNT_W'(1);
    assign trunc_hit = ops_inc >= COUNT_W'(i_op_limit);

    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + (LENGTH_BITS+4)'(digit);
    assign ref_sum  = {1'b0, r_ref} + (SUM_W+1)'(r_acc);
    assign read_sum = {1'b0, r_read} + (SUM_W+1)'(r_acc);
    assign read_upd = ((code == OP_M) || (code == OP_I) || (code == OP_S))
                    ? (read_sum[SUM_W] ? SUM_MAX : read_sum[SUM_W-1:0]) : r_read;
    assign clip_raw = ({3'b000, r_in.seq_len} > read_upd)
                    ? ({3'b000, r_in.seq_len} - read_upd) : '0;

    always_comb begin
        n_phase = r_phase;
        if (advance) begin
            priority if (r_in.end_of_string) begin
                n_phase = PH_START;
            end else if ((r_phase == PH_START) && is_star) begin
                n_phase = PH_IGNORE;
            end else if (active && !is_digit && trunc_hit) begin
                n_phase = PH_IGNORE;
            end else if (r_phase == PH_START) begin
                n_phase = PH_PARSE;
            end
        end
    end

    always_comb begin
        n_acc   = r_acc;
        n_ref   = r_ref;
        n_read  = r_read;
        n_ops   = r_ops;
        o_push  = '0;
        o_res_a = '0;
        o_res_b = '0;
        o_res_b.op_code = OP_S;
        if (advance) begin
            if (r_in.end_of_string) begin
                o_res_a.kind          = 1'b1;
                o_res_a.op_count      = r_ops;
                o_res_a.ref_span      = r_ref;
                o_res_a.bin           = reg2bin(r_in.map_pos, r_ref);
                o_res_a.record_done   = 1'b1;
                o_push.wr_a           = 1'b1;
                n_acc  = '0;
                n_ref  = '0;
                n_read = '0;
                n_ops  = '0;
            end else if (active) begin
                if (is_digit) begin
                    n_acc = (acc_next > (LENGTH_BITS+4)'(LEN_MAX))
                          ? LEN_MAX : acc_next[LENGTH_BITS-1:0];
                end else begin
                    o_res_a.op_length = OP_LEN_W'(r_acc);
                    o_res_a.op_code   = code;
                    o_push.wr_a       = 1'b1;
                    if ((code == OP_M) || (code == OP_N) || (code == OP_D)) begin
                        n_ref = ref_sum[SUM_W] ? SUM_MAX : ref_sum[SUM_W-1:0];
                    end
                    n_read = read_upd;
                    n_acc  = '0;
                    n_ops  = ops_inc;
                    if (trunc_hit) begin
                        o_res_b.op_length = (clip_raw > LEN_MAX_W)
                                          ? OP_LEN_W'(LEN_MAX) : OP_LEN_W'(clip_raw);
                        o_push.wr_b       = 1'b1;
                        n_ops             = r_ops + COUNT_W'(2);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_START;
            r_acc      <= '0;
            r_ref      <= '0;
            r_read     <= '0;
            r_ops      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ref   <= n_ref;
            r_read  <= n_read;
            r_ops   <= n_ops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

endmodule

// ===== hdl/cbe_res_fifo.sv =====
module cbe_res_fifo import cbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  t_out_item i_res_a,
    input  t_out_item i_res_b,
    output logic      o_room,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_out_item  r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_room      = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + 2'(i_push.wr_a) + 2'(i_push.wr_b);
        n_rd_ptr = r_rd_ptr + 2'(pop);
        n_count  = r_count + 3'(i_push.wr_a) + 3'(i_push.wr_b) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.wr_a) begin
            r_mem[r_wr_ptr] <= i_res_a;
        end
        if (i_push.wr_b) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res_b;
        end
    end

endmodule

// ===== hdl/cbe_checker.sv =====
module cbe_checker import cbe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // The output queue is emptied by reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_done_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.record_done == o_out_data.kind))
        else $error("record_done does not match kind");

    a_op_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.kind |->
            (o_out_data.op_count == '0) && (o_out_data.ref_span == '0)
            && (o_out_data.bin == '0) && (o_out_data.op_code <= OP_X))
        else $error("op word carries summary fields or a bad code");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind |->
            (o_out_data.op_length == '0) && (o_out_data.op_code == OP_M))
        else $error("summary carries op fields");

endmodule

bind cigar_to_bam_op_encoder_core cbe_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
